// ----- hdl/kei_pkg.sv -----
// ----------------------------------------------------------------------------
// kei_pkg
// Shared types and constants of the keyframe eased interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

    // default number of fraction bits of progress and easing values
    localparam int FRACTION_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME    = 1'b1;

    // easing modes (code 3 behaves as linear)
    localparam logic [1:0] MODE_LINEAR    = 2'd0;
    localparam logic [1:0] MODE_SPLINE    = 2'd1;
    localparam logic [1:0] MODE_TWO_PIECE = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // per item record carried down the pipeline
    typedef struct packed {
        t_status            status;
        logic               apply;
        logic               rev;
        logic [1:0]         mode;
        logic [15:0]        bias;
        logic [15:0]        bias2;
        logic signed [31:0] start_v;
        logic signed [31:0] stop_v;
        logic [31:0]        begin_t;
        logic [31:0]        end_t;
        logic               p_zero;
        logic               p_one;
    } t_rec;

endpackage

// ----- hdl/keyframe_eased_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_eased_interpolator
// Evaluates one component of an animation record at a requested frame.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at each rising edge with start high and busy low. busy
//   is always low: the pipeline takes one item every cycle.
//   Each result appears on o_status / o_result_value for one cycle with
//   o_done high; results leave in item order. The pipeline is built around
//   two bit-per-stage divider pipelines: the time divider (48 stages) and
//   the progress divider (32 + FRACTION_BITS stages), plus the multiply and
//   easing stages around them.
//   Registers frame_count (index 0) and max_time (index 1) are written over
//   the cfg channel; o_cfg_ready is always high. The user must write them
//   only while no item is in flight; the block itself does not enforce this.
//   Synchronous active-low reset empties the pipeline and sets frame_count
//   to 1, max_time to 0. The receiver cannot stall, so nothing is held.
// ----------------------------------------------------------------------------
module keyframe_eased_interpolator #(
    parameter int FRACTION_BITS = kei_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [15:0]                   i_frame,
    input  logic [31:0]                   i_begin_time,
    input  logic [31:0]                   i_end_time,
    input  logic                          i_apply_to_start,
    input  logic                          i_reverse,
    input  logic [1:0]                    i_ease_mode,
    input  logic signed [15:0]            i_bias,
    input  logic signed [15:0]            i_bias_second,
    input  logic signed [31:0]            i_start_value,
    input  logic signed [31:0]            i_stop_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kei_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic signed [31:0]            o_result_value
);
    import kei_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int CW      = F + 4;
    localparam int EW      = F + 5;
    localparam int PRW     = 33 + EW;
    localparam int SW      = PRW - F + 1;
    localparam int DIV1_NW = 48;
    localparam int DIV2_NW = 32 + F;
    localparam int RECW    = $bits(t_rec);
    localparam int BSH_L   = (F >= 14) ? F - 14 : 0;
    localparam int BSH_R   = (F < 14) ? 14 - F : 0;
    localparam int LATENCY = 2 + (DIV1_NW + 1) + 1 + (DIV2_NW + 1) + 1 + 6;

    localparam logic [F:0]           ONE_U  = {1'b1, {F{1'b0}}};
    localparam logic [F:0]           HALF_U = {2'b01, {(F-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_S  = CW'($signed({1'b0, ONE_U}));
    localparam logic signed [CW-1:0] HALF_S = CW'($signed({1'b0, HALF_U}));

    // Q2.14 bias to F fraction bits, floor
    function automatic logic signed [CW-1:0] bias_q(input logic [15:0] raw);
        logic signed [39:0] w;
        w = 40'($signed(raw));
        w = (w <<< BSH_L) >>> BSH_R;
        return CW'(w);
    endfunction

    // configuration registers
    logic [15:0] r_frame_count;
    logic [31:0] r_max_time;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 16'd1;
            r_max_time    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[15:0];
                CFG_MAX_TIME:    r_max_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage s1: input capture
    logic        r_s1_v;
    logic [15:0] r_s1_frame;
    t_rec        r_s1_rec;
    t_rec        n_s1_rec;

    always_comb begin
        n_s1_rec         = '0;
        n_s1_rec.status  = ST_APPLIED;
        n_s1_rec.apply   = i_apply_to_start;
        n_s1_rec.rev     = i_reverse;
        n_s1_rec.mode    = i_ease_mode;
        n_s1_rec.bias    = i_bias;
        n_s1_rec.bias2   = i_bias_second;
        n_s1_rec.start_v = i_start_value;
        n_s1_rec.stop_v  = i_stop_value;
        n_s1_rec.begin_t = i_begin_time;
        n_s1_rec.end_t   = i_end_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_frame <= i_frame;
        r_s1_rec   <= n_s1_rec;
    end

    // stage s2: time product and frame range check
    logic        r_s2_v;
    logic [47:0] r_s2_prod;
    t_rec        r_s2_rec;
    t_rec        n_s2_rec;

    always_comb begin
        n_s2_rec = r_s1_rec;
        if (r_frame_count == '0 || r_s1_frame == '0 || r_s1_frame > r_frame_count) begin
            n_s2_rec.status = ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_prod <= 48'(r_max_time) * 48'(r_s1_frame);
        r_s2_rec  <= n_s2_rec;
    end

    // current time divider
    logic               w_d1_v;
    logic [DIV1_NW-1:0] w_d1_q;
    t_rec               w_d1_rec;

    kei_div #(
        .NW (DIV1_NW),
        .DW (16),
        .PW (RECW)
    ) u_div_time (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s2_v),
        .i_dividend (r_s2_prod),
        .i_divisor  (r_frame_count),
        .i_payload  (r_s2_rec),
        .o_valid    (w_d1_v),
        .o_quotient (w_d1_q),
        .o_payload  (w_d1_rec)
    );

    // stage p1: skip decision and progress operands
    logic               r_p1_v;
    logic [DIV2_NW-1:0] r_p1_num;
    logic [31:0]        r_p1_den;
    t_rec               r_p1_rec;
    t_rec               n_p1_rec;
    logic [31:0]        w_now;
    logic               w_before;

    always_comb begin
        w_now           = w_d1_q[31:0];
        w_before        = (w_now < w_d1_rec.begin_t);
        n_p1_rec        = w_d1_rec;
        n_p1_rec.p_zero = w_before;
        n_p1_rec.p_one  = !(w_d1_rec.end_t > w_d1_rec.begin_t);
        if (w_d1_rec.status == ST_APPLIED && !w_d1_rec.apply && w_before) begin
            n_p1_rec.status = ST_SKIPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_num <= {w_now - w_d1_rec.begin_t, {F{1'b0}}};
        r_p1_den <= w_d1_rec.end_t - w_d1_rec.begin_t;
        r_p1_rec <= n_p1_rec;
    end

    // progress divider
    logic               w_d2_v;
    logic [DIV2_NW-1:0] w_d2_q;
    t_rec               w_d2_rec;

    kei_div #(
        .NW (DIV2_NW),
        .DW (32),
        .PW (RECW)
    ) u_div_prog (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_p1_v),
        .i_dividend (r_p1_num),
        .i_divisor  (r_p1_den),
        .i_payload  (r_p1_rec),
        .o_valid    (w_d2_v),
        .o_quotient (w_d2_q),
        .o_payload  (w_d2_rec)
    );

    // stage p2: progress clamp
    logic       r_p2_v;
    logic [F:0] r_p2_p;
    t_rec       r_p2_rec;
    logic [F:0] n_p2_p;

    always_comb begin
        priority if (w_d2_rec.p_zero) begin
            n_p2_p = '0;
        end else if (w_d2_rec.p_one || w_d2_q > DIV2_NW'(ONE_U)) begin
            n_p2_p = ONE_U;
        end else begin
            n_p2_p = w_d2_q[F:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_p   <= n_p2_p;
        r_p2_rec <= w_d2_rec;
    end

    // stage e1: spline coefficients per easing mode
    logic                 r_e1_v;
    logic signed [CW-1:0] r_e1_u;
    logic signed [CW-1:0] r_e1_ca;
    logic signed [CW-1:0] r_e1_cb;
    logic signed [CW-1:0] r_e1_a;
    t_rec                 r_e1_rec;
    logic signed [CW-1:0] n_e1_u;
    logic signed [CW-1:0] n_e1_ca;
    logic signed [CW-1:0] n_e1_cb;
    logic signed [CW-1:0] n_e1_a;
    logic signed [CW-1:0] w_p;
    logic signed [CW-1:0] w_b1;
    logic signed [CW-1:0] w_b2;

    always_comb begin
        w_p  = CW'($signed({1'b0, r_p2_p}));
        w_b1 = bias_q(r_p2_rec.bias);
        w_b2 = bias_q(r_p2_rec.bias2);
        // linear: e = one * p
        n_e1_u  = w_p;
        n_e1_ca = '0;
        n_e1_cb = ONE_S;
        n_e1_a  = '0;
        unique case (r_p2_rec.mode)
            MODE_SPLINE: begin
                n_e1_ca = ONE_S - (w_b1 <<< 1);
                n_e1_cb = w_b1 <<< 1;
            end
            MODE_TWO_PIECE: begin
                if (r_p2_p < HALF_U) begin
                    n_e1_u  = w_p <<< 1;
                    n_e1_ca = HALF_S - (w_b1 <<< 1);
                    n_e1_cb = w_b1 <<< 1;
                end else begin
                    n_e1_u  = (w_p <<< 1) - ONE_S;
                    n_e1_a  = HALF_S;
                    n_e1_ca = HALF_S - (w_b2 <<< 1) + ONE_S;
                    n_e1_cb = (w_b2 <<< 1) - ONE_S;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else begin
            r_e1_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_u   <= n_e1_u;
        r_e1_ca  <= n_e1_ca;
        r_e1_cb  <= n_e1_cb;
        r_e1_a   <= n_e1_a;
        r_e1_rec <= r_p2_rec;
    end

    // stage e2: u squared and linear term
    logic                   r_e2_v;
    logic signed [CW-1:0]   r_e2_u2;
    logic signed [EW-1:0]   r_e2_bu;
    logic signed [CW-1:0]   r_e2_ca;
    logic signed [CW-1:0]   r_e2_a;
    t_rec                   r_e2_rec;
    logic signed [2*CW-1:0] w_uu;
    logic signed [2*CW-1:0] w_bu;

    assign w_uu = r_e1_u * r_e1_u;
    assign w_bu = r_e1_cb * r_e1_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e2_u2  <= CW'(w_uu >>> F);
        r_e2_bu  <= EW'(w_bu >>> F);
        r_e2_ca  <= r_e1_ca;
        r_e2_a   <= r_e1_a;
        r_e2_rec <= r_e1_rec;
    end

    // stage e3: quadratic term
    logic                   r_e3_v;
    logic signed [EW-1:0]   r_e3_au;
    logic signed [EW-1:0]   r_e3_bu;
    logic signed [CW-1:0]   r_e3_a;
    t_rec                   r_e3_rec;
    logic signed [2*CW-1:0] w_au;

    assign w_au = r_e2_ca * r_e2_u2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_v <= 1'b0;
        end else begin
            r_e3_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e3_au  <= EW'(w_au >>> F);
        r_e3_bu  <= r_e2_bu;
        r_e3_a   <= r_e2_a;
        r_e3_rec <= r_e2_rec;
    end

    // stage e4: eased value, base and span
    logic               r_e4_v;
    logic signed [EW-1:0] r_e4_e;
    logic signed [32:0] r_e4_diff;
    logic signed [31:0] r_e4_base;
    t_status            r_e4_status;
    logic signed [32:0] w_sv;
    logic signed [32:0] w_ev;

    assign w_sv = 33'(r_e3_rec.start_v);
    assign w_ev = 33'(r_e3_rec.stop_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_v <= 1'b0;
        end else begin
            r_e4_v <= r_e3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e4_e      <= r_e3_au + r_e3_bu + EW'(r_e3_a);
        r_e4_diff   <= r_e3_rec.rev ? (w_sv - w_ev) : (w_ev - w_sv);
        r_e4_base   <= r_e3_rec.rev ? r_e3_rec.stop_v : r_e3_rec.start_v;
        r_e4_status <= r_e3_rec.status;
    end

    // stage e5: span times eased value
    logic                  r_e5_v;
    logic signed [PRW-1:0] r_e5_prod;
    logic signed [31:0]    r_e5_base;
    t_status               r_e5_status;
    logic signed [PRW-1:0] w_prod;

    assign w_prod = r_e4_diff * r_e4_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e5_v <= 1'b0;
        end else begin
            r_e5_v <= r_e4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e5_prod   <= w_prod;
        r_e5_base   <= r_e4_base;
        r_e5_status <= r_e4_status;
    end

    // stage e6: add, saturate and present the result
    logic                  r_o_done;
    logic [1:0]            r_o_status;
    logic signed [31:0]    r_o_value;
    logic signed [PRW-1:0] w_sh;
    logic signed [SW-1:0]  w_sum;
    logic signed [31:0]    n_value;

    always_comb begin
        w_sh  = r_e5_prod >>> F;
        w_sum = SW'(r_e5_base) + SW'(w_sh);
        priority if (r_e5_status != ST_APPLIED) begin
            n_value = '0;
        end else if (w_sum > $signed({{(SW-32){1'b0}}, 32'h7FFF_FFFF})) begin
            n_value = 32'sh7FFF_FFFF;
        end else if (w_sum < $signed({{(SW-32){1'b1}}, 32'h8000_0000})) begin
            n_value = 32'sh8000_0000;
        end else begin
            n_value = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= r_e5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status <= r_e5_status;
        r_o_value  <= n_value;
    end

    assign o_done         = r_o_done;
    assign o_status       = r_o_status;
    assign o_result_value = r_o_value;

    // checks
    a_item_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_done)
        else $error("item taken but no result delivered");

    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without a matching item");

    a_zero_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_frame == '0 |-> ##LATENCY o_status == ST_RANGE)
        else $error("frame zero not flagged out of range");

    a_not_applied : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_APPLIED |-> o_result_value == '0)
        else $error("result value nonzero for a record not applied");

endmodule

// ----- hdl/kei_div.sv -----
// ----------------------------------------------------------------------------
// kei_div
// Pipelined restoring divider, one quotient bit per stage, with a payload
// that travels alongside each item.
// ----------------------------------------------------------------------------
module kei_div #(
    parameter int NW = 48,
    parameter int DW = 16,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [PW-1:0] i_payload,
    output logic          o_valid,
    output logic [NW-1:0] o_quotient,
    output logic [PW-1:0] o_payload
);
    import kei_pkg::*;

    logic [DW-1:0] r_rem [0:NW];
    logic [NW-1:0] r_q   [0:NW];
    logic [DW-1:0] r_dv  [0:NW];
    logic [PW-1:0] r_pl  [0:NW];
    logic          r_v   [0:NW];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_q[0]   <= i_dividend;
        r_dv[0]  <= i_divisor;
        r_pl[0]  <= i_payload;
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= NW; k++) begin : g_stage
        logic [DW:0]   n_sh;
        logic          n_ge;
        logic [DW-1:0] n_rem;

        always_comb begin
            n_sh  = {r_rem[k-1], r_q[k-1][NW-1]};
            n_ge  = (n_sh >= {1'b0, r_dv[k-1]});
            n_rem = n_ge ? DW'(n_sh - {1'b0, r_dv[k-1]}) : n_sh[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_q[k]   <= {r_q[k-1][NW-2:0], n_ge};
            r_dv[k]  <= r_dv[k-1];
            r_pl[k]  <= r_pl[k-1];
        end
    end

    assign o_valid    = r_v[NW];
    assign o_quotient = r_q[NW];
    assign o_payload  = r_pl[NW];

    // checks
    a_lat_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##(NW+1) o_valid)
        else $error("divider item lost");

    a_lat_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, NW+1))
        else $error("divider item invented");

    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NW] && (r_dv[NW] != '0) |-> r_rem[NW] < r_dv[NW])
        else $error("divider remainder not below divisor");

endmodule

// ----- sim/kei_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kei_checker
// Watches the item and result channels of the keyframe eased interpolator,
// predicts each result from the accepted item and the current registers,
// and compares status and value in order.
// ----------------------------------------------------------------------------
module kei_checker
    import kei_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [15:0]        i_frame,
    input  logic [31:0]        i_begin_time,
    input  logic [31:0]        i_end_time,
    input  logic               i_apply_to_start,
    input  logic               i_reverse,
    input  logic [1:0]         i_ease_mode,
    input  logic signed [15:0] i_bias,
    input  logic signed [15:0] i_bias_second,
    input  logic signed [31:0] i_start_value,
    input  logic signed [31:0] i_stop_value,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_done,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_result_value,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value;
    } t_outcome;

    logic [15:0] r_frames_total;
    logic [31:0] r_time_span;
    t_outcome    outcome_q[$];

    assign o_pending = outcome_q.size();

    // product of two fixed-point values, floored
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRACTION_BITS;
    endfunction

    function automatic longint bias_fx(logic signed [15:0] raw);
        longint b;
        b = raw;
        if (FRACTION_BITS >= 14) return b <<< (FRACTION_BITS - 14);
        return b >>> (14 - FRACTION_BITS);
    endfunction

    function automatic longint quad_curve(longint u, longint a, longint b, longint c);
        return fx_mul(a - 2 * b + c, fx_mul(u, u)) + fx_mul(2 * b - 2 * a, u) + a;
    endfunction

    function automatic t_outcome evaluate_record();
        t_outcome   r;
        longint unsigned now_t, q;
        longint     one, half, p, e, base, diff, v;
        one  = longint'(1) <<< FRACTION_BITS;
        half = longint'(1) <<< (FRACTION_BITS - 1);
        r.status = ST_APPLIED;
        r.value  = '0;
        if (r_frames_total == 0 || i_frame == 0 || i_frame > r_frames_total) begin
            r.status = ST_RANGE;
            return r;
        end
        now_t = (64'(r_time_span) * 64'(i_frame)) / 64'(r_frames_total);
        if (!i_apply_to_start && now_t < 64'(i_begin_time)) begin
            r.status = ST_SKIPPED;
            return r;
        end
        // progress clamped to one
        if (now_t < 64'(i_begin_time)) p = 0;
        else if (i_end_time > i_begin_time) begin
            q = ((now_t - 64'(i_begin_time)) << FRACTION_BITS)
                / 64'(i_end_time - i_begin_time);
            p = (q > 64'(one)) ? one : longint'(q);
        end else p = one;
        // easing
        if (i_ease_mode == MODE_SPLINE)
            e = quad_curve(p, 0, bias_fx(i_bias), one);
        else if (i_ease_mode == MODE_TWO_PIECE) begin
            if (p < half) e = quad_curve(2 * p, 0, bias_fx(i_bias), half);
            else e = quad_curve(2 * p - one, half, bias_fx(i_bias_second), one);
        end else e = p;
        base = i_reverse ? longint'(i_stop_value) : longint'(i_start_value);
        diff = i_reverse ? longint'(i_start_value) - longint'(i_stop_value)
                         : longint'(i_stop_value) - longint'(i_start_value);
        v = base + ((diff * e) >>> FRACTION_BITS);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.value = v[31:0];
        return r;
    endfunction

    // register shadow, prediction and comparison
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            r_frames_total <= 16'd1;
            r_time_span    <= '0;
            o_errors       <= 0;
            outcome_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_COUNT) r_frames_total <= i_cfg_data[15:0];
                else if (i_cfg_index == CFG_MAX_TIME) r_time_span <= i_cfg_data;
            end
            if (start && !busy) outcome_q = {outcome_q, evaluate_record()};
            if (i_done) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d value %0d",
                             $time, i_status, i_result_value);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status != want.status || i_result_value != want.value) begin
                        $display("%0t: mismatch expected status %0d value %0d, got status %0d value %0d",
                                 $time, want.status, want.value, i_status, i_result_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb_keyframe_eased_interpolator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyframe_eased_interpolator
// Drives directed and random records over several frame_count / max_time
// settings with random start gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_keyframe_eased_interpolator;
    import kei_pkg::*;

    localparam int LATENCY   = 92 + FRACTION_BITS_DEF;
    localparam int MAX_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] i_frame = '0;
    logic [31:0] i_begin_time = '0, i_end_time = '0;
    logic i_apply_to_start = 1'b0, i_reverse = 1'b0;
    logic [1:0] i_ease_mode = MODE_LINEAR;
    logic signed [15:0] i_bias = '0, i_bias_second = '0;
    logic signed [31:0] i_start_value = '0, i_stop_value = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FRAME_COUNT;
    logic [31:0] i_cfg_data = '0;
    logic o_done;
    logic [1:0] o_status;
    logic signed [31:0] o_result_value;
    int errors, pending, cycles;
    logic [15:0] frames_now;
    logic [31:0] span_now;

    always #5 i_clk = ~i_clk;

    keyframe_eased_interpolator DUT (.*);

    kei_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_frame, .i_begin_time, .i_end_time,
        .i_apply_to_start, .i_reverse, .i_ease_mode, .i_bias, .i_bias_second,
        .i_start_value, .i_stop_value, .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .i_done(o_done), .i_status(o_status),
        .i_result_value(o_result_value), .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("tb_keyframe_eased_interpolator: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] fc, input logic [31:0] mt);
        write_reg(CFG_FRAME_COUNT, 32'(fc));
        write_reg(CFG_MAX_TIME, mt);
        frames_now = fc;
        span_now   = mt;
    endtask

    // waits until every result is in, then lets the pipe drain
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [15:0] fr, input logic [31:0] bt,
                             input logic [31:0] et, input logic ap, input logic rv,
                             input logic [1:0] md, input logic [15:0] b1,
                             input logic [15:0] b2, input logic [31:0] sv,
                             input logic [31:0] ev, input bit idle);
        i_frame <= fr; i_begin_time <= bt; i_end_time <= et;
        i_apply_to_start <= ap; i_reverse <= rv; i_ease_mode <= md;
        i_bias <= b1; i_bias_second <= b2; i_start_value <= sv; i_stop_value <= ev;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (idle) begin
            start <= 1'b0;
            gap();
        end
    endtask

    // random record, mostly around the current time so progress varies
    task automatic random_item(input bit idle);
        logic [15:0] fr;
        logic [31:0] bt, et, now_t;
        case ($urandom_range(0, 9))
            0:       fr = 16'($urandom);
            1:       fr = 16'd0;
            default: fr = (frames_now == 0) ? 16'd1 : 16'($urandom_range(1, frames_now));
        endcase
        now_t = (frames_now == 0) ? 32'd0
              : 32'((64'(span_now) * 64'(fr)) / 64'(frames_now));
        if ($urandom_range(0, 4) == 0) begin
            bt = $urandom; et = $urandom;
        end else begin
            bt = now_t - 32'($urandom_range(0, 32'h0008_0000)) + 32'h0001_0000;
            et = bt + 32'($urandom_range(0, 32'h0010_0000));
        end
        send_item(fr, bt, et, 1'($urandom), 1'($urandom), 2'($urandom),
                  16'($urandom), 16'($urandom), $urandom, $urandom, idle);
    endtask

    initial begin
        int k;
        logic [15:0] fcs[5];
        logic [31:0] mts[5];
        fcs = '{16'd1, 16'd65535, 16'd100, 16'd7, 16'd0};
        mts = '{32'hFFFF_FFFF, 32'h0064_0000, 32'd0, 32'h0003_8000, 32'h0001_0000};
        frames_now = 16'd1;
        span_now   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every mode, skip, range, saturation
        set_regs(16'd10, 32'h000A_0000);
        send_item(16'd0, 0, 0, 0, 0, MODE_LINEAR, 0, 0, 1, 2, 1);
        send_item(16'd11, 0, 0, 0, 0, MODE_LINEAR, 0, 0, 1, 2, 0);
        send_item(16'hFFFF, 0, 0, 1, 1, 2'd3, 16'hFFFF, 16'hFFFF, '1, '1, 0);
        send_item(16'd5, 32'h0006_0000, 32'h0008_0000, 0, 0, MODE_LINEAR, 0, 0, 1, 2, 0);
        send_item(16'd5, 32'h0006_0000, 32'h0008_0000, 1, 0, MODE_SPLINE,
                  16'h7FFF, 0, 32'h0001_0000, 32'h0005_0000, 1);
        send_item(16'd5, 32'h0004_0000, 32'h0004_0000, 0, 1, MODE_LINEAR,
                  0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(16'd5, 32'h0004_0000, 32'h0005_0000, 0, 0, MODE_LINEAR,
                  0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(16'd10, 0, 32'h0014_0000, 0, 0, MODE_SPLINE,
                  16'h8000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_item(16'd10, 0, 32'h0014_0000, 0, 1, MODE_SPLINE,
                  16'h7FFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_item(16'd3, 0, 32'h000A_0000, 0, 0, MODE_TWO_PIECE,
                  16'h7FFF, 16'h8000, 32'hFFF0_0000, 32'h0010_0000, 0);
        send_item(16'd7, 0, 32'h000A_0000, 0, 0, MODE_TWO_PIECE,
                  16'h8000, 16'h7FFF, 32'hFFF0_0000, 32'h0010_0000, 0);
        send_item(16'd10, 32'hFFFF_FFFF, 32'h0, 1, 0, 2'd3, 0, 0, 5, 9, 1);
        start <= 1'b0;
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            set_regs(fcs[ph], mts[ph]);
            k = 0;
            while (k < 400) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(5, 30)) begin
                        random_item(0);
                        k++;
                    end
                    start <= 1'b0;
                    gap();
                end else begin
                    random_item(1);
                    k++;
                end
            end
            start <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("tb_keyframe_eased_interpolator: done, clean");
        else
            $display("tb_keyframe_eased_interpolator: done, errors");
        $finish;
    end

endmodule
